// ===== rtl/hmq_pkg.sv =====
package hmq_pkg;

	localparam int CAPACITY   = 512;
	localparam int KEY_BITS   = 32;
	localparam int TAG_BITS   = 10;
	localparam int ADDR_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	// wide enough for a right child index of the last slot
	localparam int CHILD_BITS = ADDR_BITS + 2;

	localparam int FIFO_DEPTH    = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_SWIM,
		ENG_RM_ROOT,
		ENG_RM_LAST,
		ENG_SINK_L,
		ENG_SINK_R,
		ENG_FIN,
		ENG_RESULT
	} eng_state_t;

endpackage

// ===== rtl/hmq_front.sv =====
module hmq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [hmq_pkg::KEY_BITS-1:0]  item_key,
	input  logic [hmq_pkg::TAG_BITS-1:0]  item_tag,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output hmq_pkg::cmd_t                 cmd
);
	import hmq_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	op_t  op_dec;

	always_comb begin
		case (func)
			1'b0:    op_dec = OP_INSERT;
			1'b1:    op_dec = OP_REMOVE;
			default: op_dec = OP_INSERT;
		endcase
	end

	// take a new transaction whenever the stage is empty or draining
	assign in_ready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.op  <= op_dec;
			cmd_s1.key <= item_key;
			cmd_s1.tag <= item_tag;
		end
	end

endmodule

// ===== rtl/hmq_cmd_fifo.sv =====
module hmq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hmq_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output hmq_pkg::cmd_t pop_cmd
);
	import hmq_pkg::*;

	cmd_t                     slots[FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     do_push;
	logic                     do_pop;

	assign push_ready = count_q != FIFO_CNT_BITS'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slots[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + FIFO_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - FIFO_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/hmq_engine.sv =====
module hmq_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  hmq_pkg::cmd_t                 cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [1:0]                    res_status,
	output logic [hmq_pkg::KEY_BITS-1:0]  res_key,
	output logic [hmq_pkg::TAG_BITS-1:0]  res_tag,
	output logic [hmq_pkg::CNT_BITS-1:0]  res_fill
);
	import hmq_pkg::*;

	function automatic logic [ADDR_BITS-1:0] parent_of(input logic [ADDR_BITS-1:0] p);
		logic [ADDR_BITS-1:0] pm1;
		pm1 = p - ADDR_BITS'(1);
		return pm1 >> 1;
	endfunction

	entry_t heap_mem[CAPACITY];

	eng_state_t           state_q;
	eng_state_t           state_nxt;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [ADDR_BITS-1:0] pos_q;
	entry_t               cur_q;
	entry_t               left_q;
	entry_t               rd_q;
	status_t              status_q;
	logic [KEY_BITS-1:0]  okey_q;
	logic [TAG_BITS-1:0]  otag_q;

	logic                 res_valid_q;
	status_t              res_status_q;
	logic [KEY_BITS-1:0]  res_key_q;
	logic [TAG_BITS-1:0]  res_tag_q;
	logic [CNT_BITS-1:0]  res_fill_q;

	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  wr_en;
	logic [ADDR_BITS-1:0]  wr_addr;
	entry_t                wr_data;

	logic                  is_full;
	logic                  is_empty;
	logic [ADDR_BITS-1:0]  ins_pos;
	logic [ADDR_BITS-1:0]  up_idx;
	logic                  swim_stop;
	logic [CHILD_BITS-1:0] cnt_ext;
	logic [CHILD_BITS-1:0] l_idx;
	logic [CHILD_BITS-1:0] r_idx;
	logic                  r_exists;
	entry_t                left_e;
	logic                  left_better;
	logic [KEY_BITS-1:0]   lbk;
	logic                  choose_r;
	logic                  move;
	entry_t                best_e;
	logic [ADDR_BITS-1:0]  win_idx;
	logic [CHILD_BITS-1:0] best_l;
	logic                  best_has_child;
	logic                  decide_now;
	logic                  res_load;

	assign is_full   = cnt_q == CNT_BITS'(CAPACITY);
	assign is_empty  = cnt_q == '0;
	assign ins_pos   = cnt_q[ADDR_BITS-1:0];
	assign up_idx    = parent_of(pos_q);
	// a parent with an equal key is passed
	assign swim_stop = rd_q.key < cur_q.key;

	assign cnt_ext  = CHILD_BITS'(cnt_q);
	assign l_idx    = CHILD_BITS'({pos_q, 1'b1});
	assign r_idx    = l_idx + CHILD_BITS'(1);
	assign r_exists = r_idx < cnt_ext;

	// sink: move only toward a strictly smaller child, left wins a tie
	assign left_e         = (state_q == ENG_SINK_L) ? rd_q : left_q;
	assign left_better    = left_e.key < cur_q.key;
	assign lbk            = left_better ? left_e.key : cur_q.key;
	assign choose_r       = (state_q == ENG_SINK_R) && (rd_q.key < lbk);
	assign move           = left_better || choose_r;
	assign best_e         = choose_r ? rd_q : left_e;
	assign win_idx        = choose_r ? r_idx[ADDR_BITS-1:0] : l_idx[ADDR_BITS-1:0];
	assign best_l         = CHILD_BITS'({win_idx, 1'b1});
	assign best_has_child = best_l < cnt_ext;
	assign decide_now     = ((state_q == ENG_SINK_L) && !r_exists) || (state_q == ENG_SINK_R);

	assign res_load = (state_q == ENG_RESULT) && (!res_valid_q || res_ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_INSERT) begin
						if (is_full)
							state_nxt = ENG_RESULT;
						else if (is_empty)
							state_nxt = ENG_FIN;
						else
							state_nxt = ENG_SWIM;
					end else begin
						state_nxt = is_empty ? ENG_RESULT : ENG_RM_ROOT;
					end
				end
			end
			ENG_SWIM: begin
				if (swim_stop)
					state_nxt = ENG_RESULT;
				else if (up_idx == '0)
					state_nxt = ENG_FIN;
			end
			ENG_RM_ROOT: state_nxt = ENG_RM_LAST;
			ENG_RM_LAST: begin
				if (cnt_q == '0)
					state_nxt = ENG_RESULT;
				else if (cnt_q == CNT_BITS'(1))
					state_nxt = ENG_FIN;
				else
					state_nxt = ENG_SINK_L;
			end
			ENG_SINK_L, ENG_SINK_R: begin
				if (!decide_now)
					state_nxt = ENG_SINK_R;
				else if (!move)
					state_nxt = ENG_RESULT;
				else if (best_has_child)
					state_nxt = ENG_SINK_L;
				else
					state_nxt = ENG_FIN;
			end
			ENG_FIN: state_nxt = ENG_RESULT;
			ENG_RESULT: begin
				if (res_load)
					state_nxt = ENG_IDLE;
			end
			default: state_nxt = ENG_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		cmd_pop = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			ENG_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd.op == OP_INSERT)
					rd_addr = parent_of(ins_pos);
			end
			ENG_SWIM: begin
				wr_en = 1'b1;
				if (!swim_stop) begin
					wr_data = rd_q;
					rd_addr = parent_of(up_idx);
				end
			end
			ENG_RM_ROOT: rd_addr = ADDR_BITS'(cnt_q - CNT_BITS'(1));
			ENG_RM_LAST: rd_addr = ADDR_BITS'(1);
			ENG_SINK_L, ENG_SINK_R: begin
				if (!decide_now) begin
					rd_addr = r_idx[ADDR_BITS-1:0];
				end else begin
					wr_en = 1'b1;
					if (move) begin
						wr_data = best_e;
						rd_addr = best_l[ADDR_BITS-1:0];
					end
				end
			end
			ENG_FIN: wr_en = 1'b1;
			ENG_RESULT: wr_en = 1'b0;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			heap_mem[wr_addr] <= wr_data;
		rd_q <= heap_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ENG_IDLE && cmd_valid && cmd.op == OP_INSERT && !is_full)
				cnt_q <= cnt_q + CNT_BITS'(1);
			else if (state_q == ENG_RM_ROOT)
				cnt_q <= cnt_q - CNT_BITS'(1);
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) begin
					okey_q   <= '0;
					otag_q   <= '0;
					cur_q    <= '{key: cmd.key, tag: cmd.tag};
					pos_q    <= ins_pos;
					if (cmd.op == OP_INSERT && is_full)
						status_q <= ST_FULL;
					else if (cmd.op == OP_REMOVE && is_empty)
						status_q <= ST_EMPTY;
					else
						status_q <= ST_DONE;
				end
			end
			ENG_SWIM: begin
				if (!swim_stop)
					pos_q <= up_idx;
			end
			ENG_RM_ROOT: begin
				okey_q <= rd_q.key;
				otag_q <= rd_q.tag;
			end
			ENG_RM_LAST: begin
				cur_q <= rd_q;
				pos_q <= '0;
			end
			ENG_SINK_L, ENG_SINK_R: begin
				if (state_q == ENG_SINK_L)
					left_q <= rd_q;
				if (decide_now && move)
					pos_q <= win_idx;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_status_q <= status_q;
			res_key_q    <= okey_q;
			res_tag_q    <= otag_q;
			res_fill_q   <= cnt_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_key    = res_key_q;
	assign res_tag    = res_tag_q;
	assign res_fill   = res_fill_q;

endmodule

// ===== rtl/binary_min_heap_queue_unit.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    func, item_key, item_tag
// out      out_valid / out_ready  status, out_key, out_tag, fill_count
//
// One transaction at a time in the heap engine, which does one read and one
// write of the heap memory a cycle at most; a refused transaction goes
// straight to the result, an insert swims the new entry up from the next
// free slot and a remove sinks the last entry down from the root.
// A front register and a two-entry command queue keep accepting while the
// engine works or a result waits on out_ready. Reset clears only control.
module binary_min_heap_queue_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [hmq_pkg::KEY_BITS-1:0]  item_key,
	input  logic [hmq_pkg::TAG_BITS-1:0]  item_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [hmq_pkg::KEY_BITS-1:0]  out_key,
	output logic [hmq_pkg::TAG_BITS-1:0]  out_tag,
	output logic [hmq_pkg::CNT_BITS-1:0]  fill_count
);
	import hmq_pkg::*;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	hmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.item_key  (item_key),
		.item_tag  (item_tag),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	hmq_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	hmq_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_pop    (q_pop),
		.cmd        (q_cmd),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res_status (status),
		.res_key    (out_key),
		.res_tag    (out_tag),
		.res_fill   (fill_count)
	);

endmodule
